// ----- hw/rtl/buddy_page_allocator_unit_macros.svh -----
// Assertion macros shared by the buddy page allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");

// next-cycle implication, disabled during reset
`define BPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");

`endif

// ----- hw/rtl/bpa_pkg.sv -----
// Shared types and constants of the buddy page allocator.
// No dependencies; used by bpa_ctrl, bpa_datapath and the top level.
`default_nettype none

package bpa_pkg;

   localparam int NUM_FRAMES_DEF = 16384;
   localparam int TOP_ORDER_DEF  = 10;
   localparam int FRAME_W        = 14;
   localparam int LEN_W          = 15;
   localparam int ORD_W          = 4;
   localparam int ST_W           = 3;
   localparam int PCNT_W         = 15;
   localparam logic [PCNT_W-1:0] PAGE_COUNT_RST = 15'd16384;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_ALLOC = 2'd1;
   localparam logic [1:0] REQ_FREE  = 2'd2;
   localparam logic [1:0] REQ_RSV   = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_NOMEM = 3'd1;
   localparam logic [ST_W-1:0] ST_RES   = 3'd2;
   localparam logic [ST_W-1:0] ST_FREE  = 3'd3;
   localparam logic [ST_W-1:0] ST_RANGE = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [FRAME_W-1:0] frame_number;
      logic [LEN_W-1:0]   region_length;
      logic [ORD_W-1:0]   req_order;
   } req_payload_type;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [FRAME_W-1:0] result_frame;
      logic [ORD_W-1:0]   result_order;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      OP_CLEAR, OP_IDLE, OP_DISP, OP_ADD_STEP, OP_RB_ST, OP_RB_CHK, OP_RB_WR,
      OP_UL_INIT, OP_UL_RD, OP_UL_CHK, OP_UL_WPREV, OP_UL_WHIT, OP_ALLOC_KEEP,
      OP_ALLOC_SPLIT, OP_ALLOC_WR, OP_FREE_RD, OP_FREE_CHK, OP_MRG_ST, OP_MRG_CHK,
      OP_MRG_ABS, OP_FREE_WR, OP_RSV_RD, OP_RSV_CHK, OP_DONE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       clr_last;
      logic       fn_oob;
      logic       alloc_fail;
      logic       len_zero;
      logic       rb_oob;
      logic       rd_listed;
      logic       rd_res;
      logic       rd_free;
      logic       ul_have;
      logic       ul_hit;
      logic       ul_have_prev;
      logic       k_gt_ro;
      logic       mrg_end;
      logic       mrg_bad;
   } stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bpa_datapath.sv -----
// Datapath of the buddy allocator: frame table memory, list heads, working registers.
// Depends on bpa_pkg; driven by bpa_ctrl commands.
`default_nettype none

module bpa_datapath #(
   parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF,
   parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bpa_pkg::cmd_type         cmd,
   output bpa_pkg::stat_type             stat,
   input  wire bpa_pkg::req_payload_type req_payload,
   output bpa_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_we,
   input  wire logic [bpa_pkg::PCNT_W-1:0] csr_data
);
   import bpa_pkg::*;

   localparam int AW  = $clog2(NUM_FRAMES);
   localparam int OW  = $clog2(TOP_ORDER + 1);
   localparam int IW0 = (AW > LEN_W) ? AW : LEN_W;
   localparam int IW  = ((IW0 > TOP_ORDER) ? IW0 : TOP_ORDER) + 1;

   typedef struct packed {
      logic          free_f;
      logic          res_f;
      logic          head_f;
      logic          link_f;
      logic [OW-1:0] order;
      logic [AW-1:0] next;
   } ent_type;

   ent_type mem [NUM_FRAMES];
   ent_type rd_ff;
   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] wr_addr;
   ent_type       wr_data;

   logic [AW-1:0]  clr_ff;
   logic [TOP_ORDER:0] head_ok_ff;
   logic [AW-1:0]  head_idx_ff [TOP_ORDER+1];
   logic           hd_we;
   logic [OW-1:0]  hd_k;
   logic           hd_ok;
   logic [AW-1:0]  hd_idx;
   logic [PCNT_W-1:0] pcnt_ff;

   logic [1:0]       kind_ff;
   logic [IW-1:0]    fn_ff;
   logic [LEN_W-1:0] len_ff;
   logic [ORD_W-1:0] ro_ff;
   logic [IW-1:0]    cur_ff;
   logic [OW-1:0]    k_ff;
   logic [IW-1:0]    rb_f_ff;
   logic [OW-1:0]    rb_k_ff;
   logic [OW-1:0]    ul_k_ff;
   logic [IW-1:0]    ul_f_ff;
   logic [AW-1:0]    ul_cur_ff;
   logic             ul_have_ff;
   logic             ul_have_prev_ff;
   logic [AW-1:0]    ul_prev_ff;
   ent_type          prev_ent_ff;
   ent_type          hit_ent_ff;
   logic             keep_res_ff;
   logic [OW-1:0]    ce_order_ff;
   logic [AW-1:0]    ce_next_ff;
   logic [ST_W-1:0]  st_ff;
   logic [FRAME_W-1:0] rf_ff;
   logic [ORD_W-1:0] rk_ff;
   rsp_payload_type  rsp_ff;

   logic [IW-1:0] lim;
   logic [IW-1:0] peer;
   logic [OW-1:0] kf;
   logic          none;
   logic [OW-1:0] bk;
   logic [OW-1:0] rd_ord_cap;
   logic          rd_listed;
   logic [IW-1:0] fn_in;

   assign fn_in = IW'(req_payload.frame_number);
   assign lim = (IW'(pcnt_ff) < IW'(NUM_FRAMES)) ? IW'(pcnt_ff) : IW'(NUM_FRAMES);
   assign peer = cur_ff ^ (IW'(1) << k_ff);
   assign rd_listed = rd_ff.free_f & rd_ff.head_f;
   assign rd_ord_cap = (32'(rd_ff.order) > TOP_ORDER) ? OW'(TOP_ORDER) : rd_ff.order;

   // lowest non-empty list at or above the requested order
   always_comb begin
      none = 1'b1;
      kf   = '0;
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if (head_ok_ff[i] && (i >= 32'(ro_ff))) begin
            none = 1'b0;
            kf   = OW'(i);
         end
      end
   end

   // largest aligned block that fits the remaining length
   always_comb begin
      int fl;
      int tz;
      int m;
      fl = 0;
      tz = IW;
      for (int i = 0; i < LEN_W; i++) begin
         if (len_ff[i]) fl = i;
      end
      for (int i = IW - 1; i >= 0; i--) begin
         if (cur_ff[i]) tz = i;
      end
      m = (fl > TOP_ORDER) ? TOP_ORDER : fl;
      if (tz < m) m = tz;
      bk = OW'(m);
   end

   always_comb begin
      stat.kind         = kind_ff;
      stat.clr_last     = (clr_ff == AW'(NUM_FRAMES - 1));
      stat.fn_oob       = (fn_ff >= lim);
      stat.alloc_fail   = (32'(ro_ff) > TOP_ORDER) || none;
      stat.len_zero     = (len_ff == '0);
      stat.rb_oob       = (rb_f_ff >= lim);
      stat.rd_listed    = rd_listed;
      stat.rd_res       = rd_ff.res_f;
      stat.rd_free      = rd_ff.free_f;
      stat.ul_have      = ul_have_ff;
      stat.ul_hit       = (IW'(ul_cur_ff) == ul_f_ff);
      stat.ul_have_prev = ul_have_prev_ff;
      stat.k_gt_ro      = (32'(k_ff) > 32'(ro_ff));
      stat.mrg_end      = (32'(k_ff) >= TOP_ORDER) || (peer >= lim);
      stat.mrg_bad      = rd_ff.res_f || !rd_listed || (rd_ff.order != k_ff);
   end

   // memory port select
   always_comb begin
      rd_addr = ul_cur_ff;
      we      = 1'b0;
      wr_addr = cur_ff[AW-1:0];
      wr_data = '0;
      hd_we   = 1'b0;
      hd_k    = k_ff;
      hd_ok   = 1'b1;
      hd_idx  = cur_ff[AW-1:0];
      case (cmd.op)
         OP_CLEAR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
         end
         OP_RB_ST: rd_addr = rb_f_ff[AW-1:0];
         OP_RB_WR: begin
            we      = 1'b1;
            wr_addr = rb_f_ff[AW-1:0];
            wr_data = '{free_f: 1'b1, res_f: 1'b0, head_f: 1'b1,
                        link_f: head_ok_ff[rb_k_ff], order: rb_k_ff,
                        next: head_ok_ff[rb_k_ff] ? head_idx_ff[rb_k_ff] : '0};
            hd_we   = 1'b1;
            hd_k    = rb_k_ff;
            hd_idx  = rb_f_ff[AW-1:0];
         end
         OP_UL_RD: rd_addr = ul_cur_ff;
         OP_UL_CHK: begin
            if ((IW'(ul_cur_ff) == ul_f_ff) && !ul_have_prev_ff) begin
               hd_we  = 1'b1;
               hd_k   = ul_k_ff;
               hd_ok  = rd_ff.link_f;
               hd_idx = rd_ff.next;
            end
         end
         OP_UL_WPREV: begin
            we             = 1'b1;
            wr_addr        = ul_prev_ff;
            wr_data        = prev_ent_ff;
            wr_data.link_f = hit_ent_ff.link_f;
            wr_data.next   = hit_ent_ff.next;
         end
         OP_UL_WHIT: begin
            we             = 1'b1;
            wr_addr        = ul_f_ff[AW-1:0];
            wr_data        = hit_ent_ff;
            wr_data.link_f = 1'b0;
            wr_data.next   = '0;
         end
         OP_ALLOC_WR: begin
            we      = 1'b1;
            wr_data = '{free_f: 1'b0, res_f: keep_res_ff, head_f: 1'b1,
                        link_f: 1'b0, order: OW'(ro_ff), next: '0};
         end
         OP_FREE_RD, OP_RSV_RD: rd_addr = fn_ff[AW-1:0];
         OP_MRG_ST: rd_addr = peer[AW-1:0];
         OP_MRG_ABS: begin
            we = 1'b1;
            if (peer < cur_ff) begin
               wr_data = '{free_f: 1'b1, res_f: 1'b0, head_f: 1'b0,
                           link_f: 1'b0, order: ce_order_ff, next: ce_next_ff};
            end else begin
               wr_addr = peer[AW-1:0];
               wr_data = '{free_f: 1'b1, res_f: 1'b0, head_f: 1'b0,
                           link_f: 1'b0, order: k_ff, next: '0};
            end
         end
         OP_FREE_WR: begin
            we      = 1'b1;
            wr_data = '{free_f: 1'b1, res_f: 1'b0, head_f: 1'b1,
                        link_f: head_ok_ff[k_ff], order: k_ff,
                        next: head_ok_ff[k_ff] ? head_idx_ff[k_ff] : '0};
            hd_we   = 1'b1;
         end
         OP_RSV_CHK: begin
            we            = !rd_ff.res_f && rd_ff.free_f;
            wr_addr       = fn_ff[AW-1:0];
            wr_data       = rd_ff;
            wr_data.res_f = 1'b1;
         end
         default: rd_addr = ul_cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   // control state: clearing sweep, list valid bits, page count
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         head_ok_ff <= '0;
         pcnt_ff    <= PAGE_COUNT_RST;
      end else begin
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (hd_we) head_ok_ff[hd_k] <= hd_ok;
         if (csr_we) pcnt_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (hd_we) head_idx_ff[hd_k] <= hd_idx;
      if (cmd.rsp_load) rsp_ff <= '{status: st_ff, result_frame: rf_ff, result_order: rk_ff};
      case (cmd.op)
         OP_IDLE: begin
            kind_ff <= req_payload.req_type;
            fn_ff   <= fn_in;
            len_ff  <= req_payload.region_length;
            ro_ff   <= req_payload.req_order;
         end
         OP_DISP: begin
            rk_ff  <= '0;
            rf_ff  <= ((kind_ff == REQ_ADD) || (kind_ff == REQ_RSV)) ?
                      fn_ff[FRAME_W-1:0] : '0;
            if (kind_ff == REQ_ALLOC) begin
               if (32'(ro_ff) > TOP_ORDER) st_ff <= ST_RANGE;
               else if (none) st_ff <= ST_NOMEM;
               else st_ff <= ST_OK;
               k_ff    <= kf;
               cur_ff  <= IW'(head_idx_ff[kf]);
               ul_k_ff <= kf;
               ul_f_ff <= IW'(head_idx_ff[kf]);
            end else begin
               st_ff  <= (fn_ff >= lim) ? ST_RANGE : ST_OK;
               cur_ff <= fn_ff;
            end
         end
         OP_ADD_STEP: begin
            if (len_ff != '0) begin
               rb_f_ff <= cur_ff;
               rb_k_ff <= bk;
               cur_ff  <= cur_ff + (IW'(1) << bk);
               len_ff  <= len_ff - (LEN_W'(1) << bk);
            end
         end
         OP_RB_CHK: begin
            ul_k_ff <= rd_ord_cap;
            ul_f_ff <= rb_f_ff;
         end
         OP_UL_INIT: begin
            ul_cur_ff       <= head_idx_ff[ul_k_ff];
            ul_have_ff      <= head_ok_ff[ul_k_ff];
            ul_have_prev_ff <= 1'b0;
         end
         OP_UL_CHK: begin
            if (IW'(ul_cur_ff) == ul_f_ff) begin
               hit_ent_ff <= rd_ff;
            end else begin
               ul_prev_ff      <= ul_cur_ff;
               prev_ent_ff     <= rd_ff;
               ul_have_prev_ff <= 1'b1;
               ul_have_ff      <= rd_ff.link_f;
               ul_cur_ff       <= rd_ff.next;
            end
         end
         OP_ALLOC_KEEP: keep_res_ff <= hit_ent_ff.res_f;
         OP_ALLOC_SPLIT: begin
            if (32'(k_ff) > 32'(ro_ff)) begin
               k_ff    <= k_ff - OW'(1);
               rb_k_ff <= k_ff - OW'(1);
               rb_f_ff <= cur_ff ^ (IW'(1) << (k_ff - OW'(1)));
            end
         end
         OP_ALLOC_WR: begin
            rf_ff <= cur_ff[FRAME_W-1:0];
            rk_ff <= ro_ff;
         end
         OP_FREE_CHK: begin
            if (rd_ff.res_f) begin
               st_ff <= ST_RES;
            end else if (rd_ff.free_f) begin
               st_ff <= ST_FREE;
            end else begin
               k_ff        <= rd_ord_cap;
               cur_ff      <= fn_ff;
               ce_order_ff <= rd_ff.order;
               ce_next_ff  <= rd_ff.next;
            end
         end
         OP_MRG_CHK: begin
            ul_k_ff <= k_ff;
            ul_f_ff <= peer;
         end
         OP_MRG_ABS: begin
            if (peer < cur_ff) begin
               cur_ff      <= peer;
               ce_order_ff <= k_ff;
               ce_next_ff  <= '0;
            end
            k_ff <= k_ff + OW'(1);
         end
         OP_FREE_WR: begin
            rf_ff <= cur_ff[FRAME_W-1:0];
            rk_ff <= ORD_W'(k_ff);
         end
         OP_RSV_CHK: begin
            if (rd_ff.res_f) st_ff <= ST_RES;
            else if (!rd_ff.free_f) st_ff <= ST_NOMEM;
         end
         default: begin
            rf_ff <= rf_ff;
         end
      endcase
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bpa_ctrl.sv -----
// Sequencer of the buddy allocator: walks each request through datapath commands.
// Depends on bpa_pkg and the assertion macro header.
`default_nettype none

`include "buddy_page_allocator_unit_macros.svh"

module bpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire bpa_pkg::stat_type stat,
   output bpa_pkg::cmd_type       cmd
);
   import bpa_pkg::*;

   typedef enum logic [23:0] {
      S_CLEAR       = 24'b1 << 0,
      S_IDLE        = 24'b1 << 1,
      S_DISP        = 24'b1 << 2,
      S_ADD_STEP    = 24'b1 << 3,
      S_RB_ST       = 24'b1 << 4,
      S_RB_CHK      = 24'b1 << 5,
      S_RB_WR       = 24'b1 << 6,
      S_UL_INIT     = 24'b1 << 7,
      S_UL_RD       = 24'b1 << 8,
      S_UL_CHK      = 24'b1 << 9,
      S_UL_WPREV    = 24'b1 << 10,
      S_UL_WHIT     = 24'b1 << 11,
      S_ALLOC_KEEP  = 24'b1 << 12,
      S_ALLOC_SPLIT = 24'b1 << 13,
      S_ALLOC_WR    = 24'b1 << 14,
      S_FREE_RD     = 24'b1 << 15,
      S_FREE_CHK    = 24'b1 << 16,
      S_MRG_ST      = 24'b1 << 17,
      S_MRG_CHK     = 24'b1 << 18,
      S_MRG_ABS     = 24'b1 << 19,
      S_FREE_WR     = 24'b1 << 20,
      S_RSV_RD      = 24'b1 << 21,
      S_RSV_CHK     = 24'b1 << 22,
      S_DONE        = 24'b1 << 23
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ul_ff, ret_ul_in;
   state_type ret_rb_ff, ret_rb_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      go;

   assign go        = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_valid_in = go ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in  = state_ff;
      ret_ul_in = ret_ul_ff;
      ret_rb_in = ret_rb_ff;
      case (state_ff)
         S_CLEAR: if (stat.clr_last) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_DISP;
         S_DISP: begin
            case (stat.kind)
               REQ_ADD:  state_in = stat.fn_oob ? S_DONE : S_ADD_STEP;
               REQ_FREE: state_in = stat.fn_oob ? S_DONE : S_FREE_RD;
               REQ_RSV:  state_in = stat.fn_oob ? S_DONE : S_RSV_RD;
               REQ_ALLOC: begin
                  if (stat.alloc_fail) begin
                     state_in = S_DONE;
                  end else begin
                     state_in  = S_UL_INIT;
                     ret_ul_in = S_ALLOC_KEEP;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_ADD_STEP: begin
            if (stat.len_zero) begin
               state_in = S_DONE;
            end else begin
               state_in  = S_RB_ST;
               ret_rb_in = S_ADD_STEP;
            end
         end
         S_RB_ST: state_in = stat.rb_oob ? ret_rb_ff : S_RB_CHK;
         S_RB_CHK: begin
            state_in = S_RB_WR;
            if (stat.rd_listed) begin
               state_in  = S_UL_INIT;
               ret_ul_in = S_RB_WR;
            end
         end
         S_RB_WR:   state_in = ret_rb_ff;
         S_UL_INIT: state_in = S_UL_RD;
         S_UL_RD:   state_in = stat.ul_have ? S_UL_CHK : ret_ul_ff;
         S_UL_CHK: begin
            if (stat.ul_hit) state_in = stat.ul_have_prev ? S_UL_WPREV : S_UL_WHIT;
            else state_in = S_UL_RD;
         end
         S_UL_WPREV:   state_in = S_UL_WHIT;
         S_UL_WHIT:    state_in = ret_ul_ff;
         S_ALLOC_KEEP: state_in = S_ALLOC_SPLIT;
         S_ALLOC_SPLIT: begin
            if (stat.k_gt_ro) begin
               state_in  = S_RB_ST;
               ret_rb_in = S_ALLOC_SPLIT;
            end else begin
               state_in = S_ALLOC_WR;
            end
         end
         S_ALLOC_WR: state_in = S_DONE;
         S_FREE_RD:  state_in = S_FREE_CHK;
         S_FREE_CHK: state_in = (stat.rd_res || stat.rd_free) ? S_DONE : S_MRG_ST;
         S_MRG_ST:   state_in = stat.mrg_end ? S_FREE_WR : S_MRG_CHK;
         S_MRG_CHK: begin
            if (stat.mrg_bad) begin
               state_in = S_FREE_WR;
            end else begin
               state_in  = S_UL_INIT;
               ret_ul_in = S_MRG_ABS;
            end
         end
         S_MRG_ABS: state_in = S_MRG_ST;
         S_FREE_WR: state_in = S_DONE;
         S_RSV_RD:  state_in = S_RSV_CHK;
         S_RSV_CHK: state_in = S_DONE;
         S_DONE:    if (go) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.rsp_load = go;
      case (state_ff)
         S_CLEAR:       cmd.op = OP_CLEAR;
         S_IDLE:        cmd.op = OP_IDLE;
         S_DISP:        cmd.op = OP_DISP;
         S_ADD_STEP:    cmd.op = OP_ADD_STEP;
         S_RB_ST:       cmd.op = OP_RB_ST;
         S_RB_CHK:      cmd.op = OP_RB_CHK;
         S_RB_WR:       cmd.op = OP_RB_WR;
         S_UL_INIT:     cmd.op = OP_UL_INIT;
         S_UL_RD:       cmd.op = OP_UL_RD;
         S_UL_CHK:      cmd.op = OP_UL_CHK;
         S_UL_WPREV:    cmd.op = OP_UL_WPREV;
         S_UL_WHIT:     cmd.op = OP_UL_WHIT;
         S_ALLOC_KEEP:  cmd.op = OP_ALLOC_KEEP;
         S_ALLOC_SPLIT: cmd.op = OP_ALLOC_SPLIT;
         S_ALLOC_WR:    cmd.op = OP_ALLOC_WR;
         S_FREE_RD:     cmd.op = OP_FREE_RD;
         S_FREE_CHK:    cmd.op = OP_FREE_CHK;
         S_MRG_ST:      cmd.op = OP_MRG_ST;
         S_MRG_CHK:     cmd.op = OP_MRG_CHK;
         S_MRG_ABS:     cmd.op = OP_MRG_ABS;
         S_FREE_WR:     cmd.op = OP_FREE_WR;
         S_RSV_RD:      cmd.op = OP_RSV_RD;
         S_RSV_CHK:     cmd.op = OP_RSV_CHK;
         S_DONE:        cmd.op = OP_DONE;
         default:       cmd.op = OP_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ul_ff    <= S_DONE;
         ret_rb_ff    <= S_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ul_ff    <= ret_ul_in;
         ret_rb_ff    <= ret_rb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BPA_ASSERT_NEXT(a_take_dispatch, clock, reset, req_valid && !req_stall, state_ff == S_DISP)
   `BPA_ASSERT_NEXT(a_done_holds, clock, reset, state_ff == S_DONE && rsp_valid_ff && rsp_stall, state_ff == S_DONE)
   `BPA_ASSERT_NEXT(a_done_loads, clock, reset, go, rsp_valid_ff && state_ff == S_IDLE)
   `BPA_ASSERT_NEXT(a_clear_exit, clock, reset, state_ff == S_CLEAR, state_ff == S_CLEAR || state_ff == S_IDLE)

endmodule

`default_nettype wire

// ----- hw/rtl/buddy_page_allocator_unit.sv -----
// Buddy page allocator, top level: free lists per order over a page frame table.
// Request beats enter on req_valid/req_stall, one response beat per request leaves on
// rsp_valid/rsp_stall; the page count register is written through csr_valid/csr_data.
// Request kinds: add a free region, allocate a block, free a block, reserve a frame.
// After reset the frame table is swept clear, one entry per cycle over all NUM_FRAMES entries;
// req_stall stays high during the sweep, csr writes are taken at any time.
// An add writes its region one aligned block at a time, an allocate splits one order at
// a time down to the requested order, a free merges one order at a time; every list
// unlink walks its list from the head up to the target entry.
// One request is in flight at a time; a new one is taken once the current response
// has been placed in the output register, even while that register waits on rsp_stall.
// A stalled response beat holds its value until taken.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
`default_nettype none

module buddy_page_allocator_unit #(
   parameter int NUM_FRAMES = bpa_pkg::NUM_FRAMES_DEF,
   parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire bpa_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output bpa_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [bpa_pkg::PCNT_W-1:0] csr_data
);
   import bpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // the register is always writable
   assign csr_ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpa_datapath #(
      .NUM_FRAMES (NUM_FRAMES),
      .TOP_ORDER  (TOP_ORDER)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_data    (csr_data)
   );

endmodule

`default_nettype wire

// ----- dv/bpa_frame_checker.sv -----
// Checker for the buddy page allocator: watches request, response and csr beats.
// Holds its own frame table and free lists, predicts each response and compares.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_frame_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  bpa_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  bpa_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [bpa_pkg::PCNT_W-1:0] csr_data,
   output int                       fail_count,
   output int                       pending,
   output int                       checked
);
   import bpa_pkg::*;

   localparam int NF   = NUM_FRAMES_DEF;
   localparam int TOPK = TOP_ORDER_DEF;
   localparam logic [3:0] F_FREE = 4'd1;
   localparam logic [3:0] F_RES  = 4'd2;
   localparam logic [3:0] F_HEAD = 4'd4;
   localparam logic [3:0] F_LINK = 4'd8;

   logic [3:0]        fl[NF];
   logic [3:0]        ordk[NF];
   logic [13:0]       nxt[NF];
   logic [13:0]       hd[TOPK+1];
   logic              hv[TOPK+1];
   logic [PCNT_W-1:0] pcnt;
   rsp_payload_type   grants_q[$];

   function automatic int lim();
      return (pcnt < NF) ? int'(pcnt) : NF;
   endfunction

   function automatic void push_list(int k, int f);
      if (hv[k]) begin
         nxt[f] = hd[k];
         fl[f] = fl[f] | F_LINK;
      end else begin
         nxt[f] = '0;
         fl[f] = fl[f] & ~F_LINK;
      end
      hd[k] = f[13:0];
      hv[k] = 1'b1;
   endfunction

   function automatic void unlink_list(int k, int f);
      bit have_cur, have_prev, nv;
      int cur, prev, nx;
      have_cur = hv[k];
      cur = hd[k];
      have_prev = 0;
      prev = 0;
      for (int steps = 0; steps <= NF && have_cur; steps++) begin
         nv = fl[cur][3];
         nx = nxt[cur];
         if (cur == f) begin
            if (have_prev) begin
               nxt[prev] = nx[13:0];
               fl[prev] = (fl[prev] & ~F_LINK) | (nv ? F_LINK : 4'd0);
            end else begin
               hd[k] = nx[13:0];
               hv[k] = nv;
            end
            fl[f] = fl[f] & ~F_LINK;
            nxt[f] = '0;
            return;
         end
         have_prev = 1;
         prev = cur;
         have_cur = nv;
         cur = nx;
      end
   endfunction

   function automatic bit listed(int f);
      return (fl[f] & (F_FREE | F_HEAD)) == (F_FREE | F_HEAD);
   endfunction

   function automatic void enlist(int f, int k);
      if (f >= lim()) return;
      if (listed(f)) unlink_list((ordk[f] <= TOPK) ? int'(ordk[f]) : TOPK, f);
      fl[f] = F_FREE | F_HEAD;
      ordk[f] = k[3:0];
      push_list(k, f);
   endfunction

   function automatic rsp_payload_type predict_grant(req_payload_type r);
      rsp_payload_type g;
      int fn, len, ro, lm, cur, k, f, peer;
      g = '0;
      fn = r.frame_number;
      len = r.region_length;
      ro = r.req_order;
      lm = lim();
      case (r.req_type)
         REQ_ADD: begin
            g.result_frame = r.frame_number;
            if (fn >= lm) g.status = ST_RANGE;
            else begin
               cur = fn;
               while (len > 0) begin
                  k = $clog2(len + 1) - 1;
                  if (k > TOPK) k = TOPK;
                  while (k > 0 && (cur & ((1 << k) - 1)) != 0) k--;
                  enlist(cur, k);
                  cur += 1 << k;
                  len -= 1 << k;
               end
            end
         end
         REQ_ALLOC: begin
            if (ro > TOPK) g.status = ST_RANGE;
            else begin
               k = ro;
               while (k <= TOPK && !hv[k]) k++;
               if (k > TOPK) g.status = ST_NOMEM;
               else begin
                  f = hd[k];
                  unlink_list(k, f);
                  while (k > ro) begin
                     k--;
                     enlist(f ^ (1 << k), k);
                  end
                  fl[f] = (fl[f] & F_RES) | F_HEAD;
                  ordk[f] = ro[3:0];
                  g.result_frame = f[13:0];
                  g.result_order = ro[3:0];
               end
            end
         end
         REQ_FREE: begin
            if (fn >= lm) g.status = ST_RANGE;
            else if (fl[fn] & F_RES) g.status = ST_RES;
            else if (fl[fn] & F_FREE) g.status = ST_FREE;
            else begin
               cur = fn;
               k = (ordk[fn] <= TOPK) ? int'(ordk[fn]) : TOPK;
               fl[fn] = F_FREE | F_HEAD;
               while (k < TOPK) begin
                  peer = cur ^ (1 << k);
                  if (peer >= lm || (fl[peer] & F_RES) != 0) break;
                  if (!listed(peer) || ordk[peer] != k) break;
                  unlink_list(k, peer);
                  if (peer < cur) begin
                     fl[cur] = fl[cur] & ~F_HEAD;
                     cur = peer;
                  end else begin
                     fl[peer] = fl[peer] & ~F_HEAD;
                  end
                  k++;
               end
               fl[cur] = (fl[cur] & F_RES) | F_FREE | F_HEAD;
               ordk[cur] = k[3:0];
               push_list(k, cur);
               g.result_frame = cur[13:0];
               g.result_order = k[3:0];
            end
         end
         default: begin
            g.result_frame = r.frame_number;
            if (fn >= lm) g.status = ST_RANGE;
            else if (fl[fn] & F_RES) g.status = ST_RES;
            else if (!(fl[fn] & F_FREE)) g.status = ST_NOMEM;
            else fl[fn] = fl[fn] | F_RES;
         end
      endcase
      return g;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < NF; i++) begin
            fl[i] = '0;
            ordk[i] = '0;
            nxt[i] = '0;
         end
         for (int k = 0; k <= TOPK; k++) begin
            hd[k] = '0;
            hv[k] = 1'b0;
         end
         pcnt = PAGE_COUNT_RST;
         grants_q.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_q.size() == 0) begin
               $error("response beat with nothing outstanding");
               fail_count++;
            end else begin
               want = grants_q.pop_front();
               checked++;
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
                  fail_count++;
               end
               if (rsp_payload.result_frame !== want.result_frame) begin
                  $error("result_frame: expected %0d, got %0d",
                         want.result_frame, rsp_payload.result_frame);
                  fail_count++;
               end
               if (rsp_payload.result_order !== want.result_order) begin
                  $error("result_order: expected %0d, got %0d",
                         want.result_order, rsp_payload.result_order);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) pcnt = csr_data;
         if (req_valid && !req_stall) grants_q.push_back(predict_grant(req_payload));
      end
      pending = grants_q.size();
   end

endmodule

// ----- dv/tb.sv -----
// Testbench top for buddy_page_allocator_unit: clock, reset, stimulus and verdict.
// Depends on bpa_pkg, the block itself and bpa_frame_checker.
`timescale 1ns / 1ps

module tb;
   import bpa_pkg::*;

   localparam int CYCLE_LIMIT = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [PCNT_W-1:0] csr_data = '0;

   int fail_count, pending, checked;
   int cycles = 0;
   int cur_pc = 16384;
   int stall_left = 0;
   bit quiet = 0;
   int kind_cnt[4];
   logic [1:0] kinds_q[$];
   logic [FRAME_W-1:0] held_q[$];
   logic [FRAME_W-1:0] seen_q[$];

   buddy_page_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   bpa_frame_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("buddy_page_allocator_unit verification failed");
         $finish;
      end
   end

   // note allocated blocks so that later frees hit real blocks
   always @(posedge clock) begin
      logic [1:0] kd;
      if (!reset && rsp_valid && !rsp_stall && kinds_q.size() > 0) begin
         kd = kinds_q.pop_front();
         if (kd == REQ_ALLOC && rsp_payload.status == ST_OK)
            held_q.push_back(rsp_payload.result_frame);
      end
   end

   // receiver stalls in random bursts with a gap between, none once quiet
   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_stall = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall = 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
         rsp_stall = 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic send_beat(logic [1:0] kd, int fn, int len, int ro);
      if (!quiet && $urandom_range(0, 9) < 3) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.req_type = kd;
      req_payload.frame_number = fn[FRAME_W-1:0];
      req_payload.region_length = len[LEN_W-1:0];
      req_payload.req_order = ro[ORD_W-1:0];
      kinds_q.push_back(kd);
      kind_cnt[kd]++;
      if (kd == REQ_ADD) seen_q.push_back(fn[FRAME_W-1:0]);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_page_count(int pc);
      csr_valid = 1'b1;
      csr_data = pc[PCNT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_pc = pc;
   endtask

   function automatic int pick_frame();
      int top;
      top = (cur_pc > 16384) ? 16383 : cur_pc - 1;
      if (top < 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 16383);
      return $urandom_range(0, top);
   endfunction

   task automatic random_run(int n);
      int r, fn, len, idx;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            fn = pick_frame();
            if ($urandom_range(0, 1)) fn = fn & ~((1 << $urandom_range(0, 6)) - 1);
            r = $urandom_range(0, 19);
            len = (r == 0) ? $urandom_range(0, 16384) :
                  (r < 4) ? $urandom_range(65, 1100) : $urandom_range(1, 64);
            send_beat(REQ_ADD, fn, len, $urandom_range(0, 15));
         end else if (r < 50) begin
            r = $urandom_range(0, 99);
            send_beat(REQ_ALLOC, $urandom_range(0, 16383), $urandom_range(0, 32767),
                      (r < 80) ? $urandom_range(0, 3) :
                      (r < 95) ? $urandom_range(4, 10) : $urandom_range(11, 15));
         end else if (r < 85) begin
            if (held_q.size() > 0 && $urandom_range(0, 9) < 8) begin
               idx = $urandom_range(0, held_q.size() - 1);
               fn = held_q[idx];
               held_q.delete(idx);
            end else fn = pick_frame();
            send_beat(REQ_FREE, fn, $urandom_range(0, 32767), $urandom_range(0, 15));
         end else begin
            if (seen_q.size() > 0 && $urandom_range(0, 1))
               fn = seen_q[$urandom_range(0, seen_q.size() - 1)] + $urandom_range(0, 3);
            else fn = pick_frame();
            send_beat(REQ_RSV, fn, $urandom_range(0, 32767), $urandom_range(0, 15));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_page_count(16384);

      // empty lists, then whole-memory region and the edge orders
      send_beat(REQ_ALLOC, 0, 0, 0);
      send_beat(REQ_ADD, 0, 16384, 0);
      send_beat(REQ_ALLOC, 16383, 32767, 0);
      send_beat(REQ_ALLOC, 0, 0, 10);
      send_beat(REQ_ALLOC, 0, 0, 11);
      send_beat(REQ_ALLOC, 0, 0, 15);
      send_beat(REQ_RSV, 0, 0, 0);
      send_beat(REQ_FREE, 0, 0, 0);
      send_beat(REQ_FREE, 0, 0, 0);
      send_beat(REQ_RSV, 16383, 0, 0);
      send_beat(REQ_RSV, 16383, 0, 0);
      send_beat(REQ_FREE, 16383, 0, 0);
      send_beat(REQ_ADD, 8, 0, 0);
      send_beat(REQ_ADD, 3, 29, 0);
      send_beat(REQ_ADD, 0, 16, 0);
      send_beat(REQ_ALLOC, 0, 0, 2);
      send_beat(REQ_ALLOC, 0, 0, 0);
      drain();

      random_run(400);
      drain();
      write_page_count(700);
      send_beat(REQ_ADD, 700, 4, 0);
      send_beat(REQ_FREE, 16383, 0, 0);
      send_beat(REQ_RSV, 699, 0, 0);
      random_run(300);
      drain();
      write_page_count(1);
      random_run(100);
      drain();
      write_page_count(0);
      random_run(30);
      drain();
      write_page_count(32767);
      random_run(200);
      drain();
      write_page_count(16384);
      quiet = 1;
      random_run(220);
      drain();

      $display("run: %0d adds, %0d allocates, %0d frees, %0d reserves; %0d responses checked",
               kind_cnt[REQ_ADD], kind_cnt[REQ_ALLOC], kind_cnt[REQ_FREE],
               kind_cnt[REQ_RSV], checked);
      $display("page counts covered: 0, 1, 700, 16384 and 32767");
      if (fail_count == 0) begin
         $display("buddy_page_allocator_unit verification clean");
      end else begin
         $display("buddy_page_allocator_unit verification failed");
      end
      $finish;
   end

endmodule
